// ===== sv/mtd_pkg.sv =====
// Package for the musical tick divider: the fixed division table, quotient
// constants, request codes and the request/response structs of the shared divider.
// No dependencies.
`default_nettype none

package mtd_pkg;

   localparam int DIV_W      = 13;  // signed width of one table entry
   localparam int TICK_W     = 32;  // width of the tick count field
   localparam int QUOT_W     = 33;  // unsigned width of a stored quotient
   localparam int LIST_LEN   = 22;
   localparam int LOOKUP_W   = 6;   // table index width at the largest depth
   localparam int STEP_CNT_W = $clog2(TICK_W);

   localparam logic [4:0] ENTRIES_RESET = 5'd22;

   // A quotient of all ones stands for a division that cannot be carried out.
   localparam logic [QUOT_W-1:0] NO_QUOTIENT = '1;

   typedef enum logic {
      CMD_SELECT = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef logic signed [DIV_W-1:0] division_type;

   localparam division_type DIV_LIST [LIST_LEN] = '{
      -13'sd1, 13'sd2880, 13'sd1920, 13'sd1280, 13'sd1440, 13'sd960, 13'sd640,
      13'sd720, 13'sd480, 13'sd320, 13'sd360, 13'sd240, 13'sd160, 13'sd180,
      13'sd120, 13'sd80, 13'sd90, 13'sd60, 13'sd40, 13'sd45, 13'sd30, 13'sd15
   };

   typedef struct packed {
      logic              start;
      logic [TICK_W-1:0] dividend;
      logic [DIV_W-2:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [TICK_W-1:0] quotient;
   } div_rsp_type;

   // Entries beyond the default list read as zero.
   function automatic division_type div_lookup(input logic [LOOKUP_W-1:0] idx);
      division_type res;
      res = '0;
      if (idx < LOOKUP_W'(LIST_LEN)) begin
         res = DIV_LIST[idx[4:0]];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/mtd_divider.sv =====
// Iterative restoring divider shared by all three divisions of a tick request.
// Depends on mtd_pkg for widths and the request/response structs.
`default_nettype none

module mtd_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mtd_pkg::div_req_type div_req,
   output mtd_pkg::div_rsp_type      div_rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [mtd_pkg::STEP_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [mtd_pkg::TICK_W-1:0]          dvd_ff, dvd_in;
   logic [mtd_pkg::DIV_W-2:0]           dsr_ff, dsr_in;
   logic [mtd_pkg::DIV_W-2:0]           rem_ff, rem_in;
   logic [mtd_pkg::DIV_W-1:0]           shifted;
   logic [mtd_pkg::DIV_W-1:0]           diff;
   logic                                qbit;

   // One quotient bit per cycle; the dividend register collects the quotient.
   always_comb begin
      shifted = {rem_ff, dvd_ff[mtd_pkg::TICK_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      qbit    = (shifted >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[mtd_pkg::TICK_W-2:0], qbit};
         rem_in = qbit ? diff[mtd_pkg::DIV_W-2:0] : shifted[mtd_pkg::DIV_W-2:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mtd_pkg::STEP_CNT_W'(mtd_pkg::TICK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

`default_nettype wire

// ===== sv/mtd_selector.sv =====
// Holds the entries-in-use register and the three latched divisions, and
// clamps a select request onto the table. Depends on mtd_pkg.
`default_nettype none

module mtd_selector #(
   parameter int TABLE_DEPTH = 22
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wen,
   input  wire logic [4:0]           csr_wdata,
   input  wire logic                 sel_load,
   input  wire logic [7:0]           sel_index,
   output mtd_pkg::division_type     sel_div [3]
);

   localparam logic [7:0] DEPTH8 = 8'(TABLE_DEPTH);

   logic [4:0]            entries_ff;
   mtd_pkg::division_type div_ff [3];
   logic [7:0]            used;
   logic [7:0]            last;
   logic [7:0]            want;
   logic [7:0]            lo_idx;
   logic [7:0]            hi_idx;

   always_comb begin
      used = {3'b000, entries_ff};
      if (used == 8'd0) begin
         used = 8'd1;
      end
      if (used > DEPTH8) begin
         used = DEPTH8;
      end
      last   = used - 8'd1;
      want   = (sel_index > last) ? last : sel_index;
      lo_idx = (want == 8'd0) ? want : want - 8'd1;
      hi_idx = (want == last) ? want : want + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= mtd_pkg::ENTRIES_RESET;
         div_ff[0]  <= '0;
         div_ff[1]  <= '0;
         div_ff[2]  <= '0;
      end else begin
         if (csr_wen) begin
            entries_ff <= csr_wdata;
         end
         if (sel_load) begin
            div_ff[0] <= mtd_pkg::div_lookup(lo_idx[mtd_pkg::LOOKUP_W-1:0]);
            div_ff[1] <= mtd_pkg::div_lookup(want[mtd_pkg::LOOKUP_W-1:0]);
            div_ff[2] <= mtd_pkg::div_lookup(hi_idx[mtd_pkg::LOOKUP_W-1:0]);
         end
      end
   end

   assign sel_div = div_ff;

endmodule

`default_nettype wire

// ===== sv/musical_tick_divider.sv =====
// Top level of the musical tick divider: request sequencer, quotient history
// and output register. Depends on mtd_pkg, mtd_selector and mtd_divider.
//
//  channel   direction  payload                                   handshake
//  req_      in         tuser: cmd; tdata: division_index, tick    tvalid/tready
//  rsp_      out        tdata: division_count                      tvalid/tready
//  csr_      in         wdata: entries_in_use                      wen
//
// A select request latches the three divisions and leaves the sequencer idle.
// A tick request runs the three divisions one after another through a single
// restoring divider, one bit a cycle; a division that is not positive gets no
// quotient. The sequencer then decides the result. Reset clears the control state
// and quotient history and restores 22 entries in use. While the result register is still held by a
// stalled consumer the sequencer waits before writing a new result.
`default_nettype none

module musical_tick_divider #(
   parameter int TABLE_DEPTH = 22,
   parameter int TICK_WIDTH  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [7:0] division_index, [39:8] tick_count
   input  wire logic        req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] division_count
   input  wire logic        csr_wen,
   input  wire logic [4:0]  csr_wdata
);

   localparam int EFF_W = (TICK_WIDTH < mtd_pkg::TICK_W) ? TICK_WIDTH : mtd_pkg::TICK_W;
   localparam logic [mtd_pkg::TICK_W-1:0] TICK_MASK =
      {mtd_pkg::TICK_W{1'b1}} >> (mtd_pkg::TICK_W - EFF_W);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_RUN    = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic [1:0]                   k_ff, k_in;
   logic [mtd_pkg::TICK_W-1:0]   ticks_ff;
   logic [mtd_pkg::QUOT_W-1:0]   cur_ff [3];
   logic [mtd_pkg::QUOT_W-1:0]   prev_ff [3];
   logic                         changed_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [31:0]                  rsp_data_ff;

   logic                         req_accept;
   logic                         sel_load;
   mtd_pkg::division_type        sel_div [3];
   mtd_pkg::division_type        cur_div;
   logic                         div_ok;
   mtd_pkg::div_req_type         div_req;
   mtd_pkg::div_rsp_type         div_rsp;
   logic                         out_free;
   logic                         decide_go;
   logic                         suppress;
   logic                         emit;
   logic                         write_q;
   logic [mtd_pkg::QUOT_W-1:0]   q_value;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign sel_load   = req_accept && (req_tuser == mtd_pkg::CMD_SELECT);

   mtd_selector #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_selector (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .sel_load  (sel_load),
      .sel_index (req_tdata[7:0]),
      .sel_div   (sel_div)
   );

   assign cur_div = sel_div[k_ff];
   assign div_ok  = !cur_div[mtd_pkg::DIV_W-1] && (cur_div != '0);

   always_comb begin
      div_req.start    = (state_ff == ST_LOAD) && div_ok;
      div_req.dividend = ticks_ff;
      div_req.divisor  = cur_div[mtd_pkg::DIV_W-2:0];
   end

   mtd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // The new centre quotient is compared with the history before it replaces it.
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_tready;
      decide_go = (state_ff == ST_DECIDE) && out_free;
      suppress  = changed_ff && ((cur_ff[1] == prev_ff[0]) || (cur_ff[1] == prev_ff[1]) ||
                                 (cur_ff[1] == prev_ff[2]));
      emit      = !suppress && (cur_ff[1] != prev_ff[1]) && (cur_ff[1] != mtd_pkg::NO_QUOTIENT);
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || (decide_go && emit);
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      write_q  = 1'b0;
      q_value  = mtd_pkg::NO_QUOTIENT;
      unique case (state_ff)
         ST_IDLE: begin
            k_in = 2'd0;
            if (req_accept && (req_tuser == mtd_pkg::CMD_TICK)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (div_ok) begin
               state_in = ST_RUN;
            end else begin
               write_q  = 1'b1;
               state_in = (k_ff == 2'd2) ? ST_DECIDE : ST_LOAD;
               k_in     = (k_ff == 2'd2) ? k_ff : k_ff + 2'd1;
            end
         end
         ST_RUN: begin
            if (div_rsp.done) begin
               write_q  = 1'b1;
               q_value  = {1'b0, div_rsp.quotient};
               state_in = (k_ff == 2'd2) ? ST_DECIDE : ST_LOAD;
               k_in     = (k_ff == 2'd2) ? k_ff : k_ff + 2'd1;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= 2'd0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            cur_ff[i]  <= '0;
            prev_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (sel_load) begin
            changed_ff <= 1'b1;
         end else if (decide_go) begin
            changed_ff <= 1'b0;
         end
         if (req_accept && (req_tuser == mtd_pkg::CMD_TICK)) begin
            for (int i = 0; i < 3; i++) begin
               prev_ff[i] <= cur_ff[i];
            end
         end
         if (write_q) begin
            cur_ff[k_ff] <= q_value;
         end
      end
      if (req_accept && (req_tuser == mtd_pkg::CMD_TICK)) begin
         ticks_ff <= req_tdata[39:8] & TICK_MASK;
      end
      if (decide_go && emit) begin
         rsp_data_ff <= cur_ff[1][31:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sim/tick_division_checker.sv =====
// Checker of the musical tick divider: it watches the request, result and
// register channels, predicts each division count and compares it.
// Depends on mtd_pkg.

module tick_division_checker #(
   parameter int TABLE_DEPTH = 22
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,   // [7:0] division_index, [39:8] tick_count
   input  wire logic        req_tuser,   // cmd
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // [31:0] division_count
   input  wire logic        csr_wen,
   input  wire logic [4:0]  csr_wdata,
   output int unsigned      pending_results,
   output int unsigned      mismatch_count,
   output int unsigned      counts_checked
);

   logic [4:0]                 entries_in_use;
   mtd_pkg::division_type      chosen_div [3];
   logic [mtd_pkg::QUOT_W-1:0] quot_now [3];
   logic [mtd_pkg::QUOT_W-1:0] quot_before [3];
   logic                       fresh_selection;
   logic [31:0]                expected_counts [$];
   int unsigned                mismatches;
   int unsigned                checked;

   function automatic mtd_pkg::division_type table_entry(input int unsigned idx);
      if (idx < mtd_pkg::LIST_LEN && idx < TABLE_DEPTH) begin
         return mtd_pkg::DIV_LIST[5'(idx)];
      end
      return '0;
   endfunction

   // The selection and its two neighbours are clamped to the entries in use.
   function automatic void latch_divisions(input logic [7:0] wanted);
      int unsigned span;
      int unsigned last_idx;
      int unsigned pick;
      span = {27'd0, entries_in_use};
      if (span == 0) begin
         span = 1;
      end
      if (span > TABLE_DEPTH) begin
         span = TABLE_DEPTH;
      end
      last_idx = span - 1;
      pick = ({24'd0, wanted} > last_idx) ? last_idx : {24'd0, wanted};
      chosen_div[0] = table_entry(pick == 0 ? 0 : pick - 1);
      chosen_div[1] = table_entry(pick);
      chosen_div[2] = table_entry(pick == last_idx ? pick : pick + 1);
      fresh_selection = 1'b1;
   endfunction

   function automatic void count_ticks(input logic [mtd_pkg::TICK_W-1:0] ticks);
      logic hold_back;
      int   k;
      hold_back = 1'b0;
      for (k = 0; k < 3; k++) begin
         quot_before[k] = quot_now[k];
         if (chosen_div[k] <= 0) begin
            quot_now[k] = mtd_pkg::NO_QUOTIENT;
         end else begin
            quot_now[k] = mtd_pkg::QUOT_W'(ticks /
                          mtd_pkg::TICK_W'($unsigned(chosen_div[k])));
         end
      end
      // The first tick after a selection stays silent if its centre count
      // matches any count of the old selection.
      if (fresh_selection) begin
         for (k = 0; k < 3; k++) begin
            if (quot_now[1] == quot_before[k]) begin
               hold_back = 1'b1;
            end
         end
         fresh_selection = 1'b0;
      end
      if (!hold_back && quot_now[1] != quot_before[1] &&
          quot_now[1] != mtd_pkg::NO_QUOTIENT) begin
         expected_counts.push_back(quot_now[1][31:0]);
      end
   endfunction

   function automatic void check_count(input logic [31:0] got);
      logic [31:0] wanted;
      if (expected_counts.size() == 0) begin
         $display("%0t: division_count %0d arrived, none expected", $time, got);
         mismatches++;
      end else begin
         wanted = expected_counts.pop_front();
         checked++;
         if (got !== wanted) begin
            $display("%0t: division_count expected %0d, got %0d", $time, wanted, got);
            mismatches++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         entries_in_use = mtd_pkg::ENTRIES_RESET;
         for (int k = 0; k < 3; k++) begin
            chosen_div[k]  = '0;
            quot_now[k]    = '0;
            quot_before[k] = '0;
         end
         fresh_selection = 1'b0;
         expected_counts.delete();
         mismatches = 0;
         checked    = 0;
      end else begin
         // A result accepted now always belongs to an older request.
         if (rsp_tvalid && rsp_tready) begin
            check_count(rsp_tdata);
         end
         if (csr_wen) begin
            entries_in_use = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == mtd_pkg::CMD_SELECT) begin
               latch_divisions(req_tdata[7:0]);
            end else begin
               count_ticks(req_tdata[39:8]);
            end
         end
      end
      pending_results <= expected_counts.size();
      mismatch_count  <= mismatches;
      counts_checked  <= checked;
   end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the musical tick divider: clock, reset, request and
// register stimulus, result back-pressure and the verdict. Depends on mtd_pkg,
// tick_division_checker and musical_tick_divider.

module tb_top;

   localparam int SETTLE_CYCLES = 160;
   localparam int STALL_LIMIT   = 3000;
   localparam int PHASES        = 9;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire logic   req_tready;
   logic [39:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   wire logic   rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire logic [31:0] rsp_tdata;
   logic        csr_wen    = 1'b0;
   logic [4:0]  csr_wdata  = '0;

   int unsigned pending_results;
   int unsigned mismatch_count;
   int unsigned counts_checked;
   int unsigned sent_selects  = 0;
   int unsigned sent_ticks    = 0;
   int unsigned req_calm      = 0;
   int unsigned rsp_calm      = 0;
   int unsigned quiet_cycles  = 0;
   logic [31:0] transport_ticks = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   musical_tick_divider u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   tick_division_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count),
      .counts_checked  (counts_checked)
   );

   // Mostly random waits, with the odd calm stretch of back-to-back traffic.
   function automatic int unsigned draw_gap(inout int unsigned calm_left);
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(15, 40);
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic send_request(input mtd_pkg::cmd_type kind, input logic [7:0] idx,
                               input logic [31:0] ticks);
      int unsigned gap;
      gap = draw_gap(req_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {ticks, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == mtd_pkg::CMD_SELECT) begin
         sent_selects++;
      end else begin
         sent_ticks++;
      end
   endtask

   task automatic send_select(input logic [7:0] idx);
      send_request(mtd_pkg::CMD_SELECT, idx, $urandom());
   endtask

   task automatic send_tick(input logic [31:0] ticks);
      send_request(mtd_pkg::CMD_TICK, 8'($urandom_range(0, 255)), ticks);
   endtask

   task automatic wait_until_drained;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      // A tick that yields nothing may still be dividing.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_entries(input logic [4:0] value);
      req_tvalid <= 1'b0;
      wait_until_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // The transport position mostly moves forward, now and then stands still,
   // jumps or sits close to wrapping.
   function automatic logic [31:0] next_tick_count(input logic after_select);
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (after_select && roll < 5) begin
         return transport_ticks;
      end
      case (roll)
         0: return $urandom();
         1: return transport_ticks;
         2: return 32'hFFFF_FFFF - $urandom_range(0, 5000);
         3: return $urandom_range(0, 200);
         default: return transport_ticks + $urandom_range(1, 3000);
      endcase
   endfunction

   function automatic logic [7:0] pick_index;
      if ($urandom_range(0, 3) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return 8'($urandom_range(0, 23));
   endfunction

   task automatic random_traffic(input int unsigned amount);
      int unsigned sent;
      int unsigned run_len;
      int unsigned choice;
      sent = 0;
      while (sent < amount) begin
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            send_select(pick_index());
            run_len = $urandom_range(2, 12);
            for (int n = 0; n < run_len; n++) begin
               transport_ticks = next_tick_count(n == 0);
               send_tick(transport_ticks);
            end
            sent += run_len + 1;
         end else if (choice < 9) begin
            if ($urandom_range(0, 1) == 0) begin
               send_select(8'($urandom_range(0, 255)));
            end else begin
               send_tick($urandom());
            end
            sent++;
         end else begin
            // Two selects in a row, then the same position again.
            send_select(pick_index());
            send_select(pick_index());
            send_tick(transport_ticks);
            sent += 3;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Back-pressure starts counting once a result is on offer, so the block
   // has to hold it while further requests queue up.
   initial begin : result_sink
      int unsigned stall;
      forever begin
         stall = draw_gap(rsp_calm);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [4:0]  phase_entries [PHASES] = '{5'd22, 5'd1, 5'd0, 5'd31, 5'd23, 5'd2,
                                              5'd12, 5'd21, 5'd22};
      int unsigned phase_items [PHASES]   = '{100, 40, 40, 100, 100, 80, 110, 100, 100};
      phase_entries[6] = 5'($urandom_range(3, 20));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Ticks before any selection, the undividable first entry, repeated and
      // extreme positions, clamped indexes and a suppressed first tick.
      send_tick(32'd1000);
      send_select(8'd0);
      send_tick(32'd5000);
      send_select(8'd1);
      send_tick(32'd5760);
      send_tick(32'd5760);
      send_tick(32'd0);
      send_tick(32'hFFFF_FFFF);
      send_select(8'd255);
      send_tick(32'hFFFF_FFFF);
      send_select(8'd20);
      send_tick(32'hFFFF_FFFF);
      send_select(8'd21);
      send_tick(32'hAAAA_AAAA);
      send_select(8'd22);
      send_tick(32'h5555_5555);
      send_select(8'd128);
      send_select(8'd2);
      send_tick(32'h5555_5555);

      for (int p = 0; p < PHASES; p++) begin
         set_entries(phase_entries[p]);
         random_traffic(phase_items[p]);
      end
      req_tvalid <= 1'b0;
      wait_until_drained();

      $display("Sent %0d selects and %0d ticks over %0d table sizes, extremes included;",
               sent_selects, sent_ticks, PHASES);
      $display("%0d division counts were compared.", counts_checked);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
